### hdl/mrg_pkg.sv
// Shared types and constants for the median radius gate.
// Holds the word structs, status codes and register indexes; no dependencies.
package mrg_pkg;

	localparam int MAX_SAMPLES = 256;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);

	localparam int VAL_W     = 16;
	localparam int REG_W     = 24;
	localparam int TAG_W     = 8;
	localparam int ACC_W     = VAL_W + REG_W;
	localparam int RND_SHIFT = 12;
	localparam int RAD_W     = ACC_W - RND_SHIFT;
	localparam int MCNT_W    = $clog2(VAL_W);
	localparam int CFG_IDX_W = 2;

	localparam logic [ACC_W-1:0] RND_HALF    = ACC_W'(1) << (RND_SHIFT - 1);
	localparam logic [VAL_W-1:0] DEGEN_LIMIT = VAL_W'(8);
	localparam logic [REG_W-1:0] MAX_RADIUS_RST = '1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGMA = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX   = 2'd3;

	// status codes
	localparam logic [2:0] STAT_OK    = 3'd0;
	localparam logic [2:0] STAT_EMPTY = 3'd1;
	localparam logic [2:0] STAT_DEGEN = 3'd2;
	localparam logic [2:0] STAT_RANGE = 3'd3;
	localparam logic [2:0] STAT_SCALE = 3'd4;

	typedef struct packed {
		logic [VAL_W-1:0] sample_value;
		logic             sample_valid;
		logic             last_sample;
		logic [TAG_W-1:0] segment_tag;
	} in_word_t;

	typedef struct packed {
		logic             accepted;
		logic [2:0]       status;
		logic [REG_W-1:0] radius;
		logic [REG_W-1:0] radius_sigma;
		logic [TAG_W-1:0] result_tag;
	} res_word_t;

endpackage

### hdl/median_radius_gate_top.sv
// Median radius gate: sample buffer, bit-serial median select, serial scaling.
// Depends on mrg_pkg.
//
//   port        dir  width   meaning
//   start/busy  in   in_word_t sample word taken when start && !busy
//   done        out  res_word_t result word valid for the single done cycle
//   cfg_we      in   idx 2, data 24  register write, taken when cfg_we is high
//
// A sample word is taken whenever start is high and busy is low. After the last
// word of a segment with n stored samples, the median is found one bit per pass
// over the buffer, 16 passes (one memory read port), then a serial shift-add
// multiply and rounding give the result; a degenerate median ends after the
// select passes, and an invalid scale or an empty segment gets its result from
// the idle state without busy going high. Otherwise busy is high meanwhile.
// Reset clears the count and registers, but sets the max register to all ones;
// the buffer needs no clearing. The receiver cannot stall: done lasts one cycle.
module median_radius_gate_top import mrg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  in_word_t             sample,
	output logic                 busy,
	output logic                 done,
	output res_word_t            result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [REG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {S_IDLE, S_SEL, S_MUL, S_RND, S_FIN} state_t;

	state_t state_q;

	logic [REG_W-1:0] scale_q, sigma_q, min_q, max_q;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [CNT_W-1:0] n_q, k_q, cnt0_q, idx_q;
	logic [VAL_W-1:0] mem [MAX_SAMPLES];
	logic [VAL_W-1:0] rd_data_s1;
	logic             rd_v_s1;
	logic [VAL_W-1:0] prefix_q, bit_q, mask_q, mul_q, med_nx;
	logic [MCNT_W-1:0] mcnt_q;
	logic [ACC_W-1:0] acc_r_q, acc_s_q;
	logic [RAD_W-1:0] rad_q, sig_q;
	logic [TAG_W-1:0] tag_q;
	logic             take, store_en, rd_en, hit, pass_end, take_one, out_rng;
	logic [REG_W-1:0] rad_sat, sig_sat;

	function automatic res_word_t make_res(logic [2:0] st, logic [REG_W-1:0] r,
		logic [REG_W-1:0] s, logic [TAG_W-1:0] tag);
		res_word_t w;
		w.accepted     = (st == STAT_OK);
		w.status       = st;
		w.radius       = r;
		w.radius_sigma = s;
		w.result_tag   = tag;
		return w;
	endfunction

	assign busy     = (state_q != S_IDLE);
	assign take     = start && !busy;
	assign store_en = take && sample.sample_valid && (count_q != CNT_W'(MAX_SAMPLES));
	assign count_nx = count_q + CNT_W'(store_en);

	// one select pass: count entries that match the decided prefix and have a 0 here
	assign rd_en    = (state_q == S_SEL) && (idx_q != n_q);
	assign hit      = rd_v_s1 && (((rd_data_s1 ^ prefix_q) & mask_q) == '0)
		&& ((rd_data_s1 & bit_q) == '0);
	assign pass_end = (state_q == S_SEL) && (idx_q == n_q) && !rd_v_s1;
	assign take_one = !(cnt0_q > k_q);
	assign med_nx   = prefix_q | (take_one ? bit_q : '0);

	assign out_rng = (rad_q < RAD_W'(min_q)) || (rad_q > RAD_W'(max_q));
	assign rad_sat = (rad_q[RAD_W-1:REG_W] != '0) ? '1 : rad_q[REG_W-1:0];
	assign sig_sat = (sig_q[RAD_W-1:REG_W] != '0) ? '1 : sig_q[REG_W-1:0];

	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[count_q[ADDR_W-1:0]] <= sample.sample_value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_v_s1 <= 1'b0;
			done    <= 1'b0;
			result  <= '0;
			scale_q <= '0;
			sigma_q <= '0;
			min_q   <= '0;
			max_q   <= MAX_RADIUS_RST;
		end else begin
			rd_v_s1 <= rd_en;
			if (cfg_we) begin
				case (cfg_idx)
					CFG_SCALE: scale_q <= cfg_data;
					CFG_SIGMA: sigma_q <= cfg_data;
					CFG_MIN:   min_q   <= cfg_data;
					CFG_MAX:   max_q   <= cfg_data;
					default:   ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					done <= take && sample.last_sample
						&& ((scale_q == '0) || (count_nx == '0));
					if (take) begin
						count_q <= sample.last_sample ? '0 : count_nx;
						if (sample.last_sample) begin
							if (scale_q == '0) begin
								result <= make_res(STAT_SCALE, '0, '0, sample.segment_tag);
							end else if (count_nx == '0) begin
								result <= make_res(STAT_EMPTY, '0, '0, sample.segment_tag);
							end else begin
								state_q <= S_SEL;
							end
						end
					end
				end
				S_SEL: begin
					done <= pass_end && bit_q[0] && (med_nx <= DEGEN_LIMIT);
					if (pass_end && bit_q[0]) begin
						if (med_nx <= DEGEN_LIMIT) begin
							result  <= make_res(STAT_DEGEN, '0, '0, tag_q);
							state_q <= S_IDLE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					done <= 1'b0;
					if (mcnt_q == '0) begin
						state_q <= S_RND;
					end
				end
				S_RND: begin
					done    <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					done    <= 1'b1;
					result  <= make_res(out_rng ? STAT_RANGE : STAT_OK, rad_sat, sig_sat, tag_q);
					state_q <= S_IDLE;
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && sample.last_sample) begin
			tag_q    <= sample.segment_tag;
			n_q      <= count_nx;
			k_q      <= count_nx >> 1;
			cnt0_q   <= '0;
			idx_q    <= '0;
			prefix_q <= '0;
			mask_q   <= '0;
			bit_q    <= {1'b1, {(VAL_W-1){1'b0}}};
		end
		case (state_q)
			S_SEL: begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					cnt0_q <= cnt0_q + CNT_W'(1);
				end
				if (pass_end) begin
					prefix_q <= med_nx;
					if (take_one) begin
						k_q <= k_q - cnt0_q;
					end
					cnt0_q <= '0;
					idx_q  <= '0;
					mask_q <= mask_q | bit_q;
					bit_q  <= bit_q >> 1;
					if (bit_q[0]) begin
						mul_q   <= med_nx;
						mcnt_q  <= MCNT_W'(VAL_W - 1);
						acc_r_q <= '0;
						acc_s_q <= '0;
					end
				end
			end
			S_MUL: begin
				// MSB-first shift-add, both scales share the multiplier bits
				acc_r_q <= (acc_r_q << 1) + (mul_q[VAL_W-1] ? ACC_W'(scale_q) : '0);
				acc_s_q <= (acc_s_q << 1) + (mul_q[VAL_W-1] ? ACC_W'(sigma_q) : '0);
				mul_q   <= mul_q << 1;
				mcnt_q  <= mcnt_q - MCNT_W'(1);
			end
			S_RND: begin
				rad_q <= RAD_W'((acc_r_q + RND_HALF) >> RND_SHIFT);
				sig_q <= RAD_W'((acc_s_q + RND_HALF) >> RND_SHIFT);
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start)))
		else $error("result word without a segment in flight");
	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.accepted) |-> (result.status == STAT_OK))
		else $error("accepted flag with a failing status");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count past buffer depth");
	a_bit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEL) |-> $onehot(bit_q))
		else $error("select bit pointer lost");
`endif

endmodule
